// File: src/dhms_pkg.sv
package dhms_pkg;

  // forecast loop bound and its counter width
  localparam int unsigned MAX_FORECAST_STEPS = 63;
  localparam int unsigned CNT_W = $clog2(MAX_FORECAST_STEPS + 1);

  // one result bit per iteration of the square root and of the divider
  localparam int unsigned ITER_STEPS = 32;
  localparam int unsigned ITER_W = $clog2(ITER_STEPS);

  // binary angle of a quarter turn
  localparam logic [31:0] QUARTER = 32'h4000_0000;
  // 2^32 / (2*pi)
  localparam logic signed [32:0] INV_TWO_PI = 33'sd683565276;

  // odd quarter-wave sine polynomial, Q30
  localparam logic signed [32:0] SIN_C1 = 33'sd1686629713;
  localparam logic signed [32:0] SIN_C3 = 33'sd693598668;
  localparam logic signed [32:0] SIN_C5 = 33'sd85569306;
  localparam logic signed [32:0] SIN_C7 = 33'sd5026995;
  localparam logic signed [32:0] SIN_C9 = 33'sd172272;

  // configuration register indexes
  localparam logic [2:0] CFG_START_X       = 3'd0;
  localparam logic [2:0] CFG_START_Y       = 3'd1;
  localparam logic [2:0] CFG_DAMPING       = 3'd2;
  localparam logic [2:0] CFG_SPEED_LIMIT   = 3'd3;
  localparam logic [2:0] CFG_FORECAST_STEP = 3'd4;

  localparam logic [16:0] DAMPING_RST     = 17'd58982;
  localparam logic [30:0] SPEED_LIMIT_RST = 31'd131072;
  localparam logic [19:0] FSTEP_RST       = 20'd6554;

  localparam logic CMD_ADVANCE  = 1'b0;
  localparam logic CMD_FORECAST = 1'b1;

  typedef struct packed {
    logic               command;
    logic signed [19:0] accel;
    logic signed [19:0] turn_rate;
    logic [19:0]        delta_time;
    logic [5:0]         step_count;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [31:0]        heading;
  } out_word_t;

  typedef enum logic [5:0] {
    OP_NOP,
    OP_LOAD,
    OP_CSIN_INIT,
    OP_SSIN_INIT,
    OP_SIN_X2,
    OP_SIN_SUB,
    OP_SIN_MUL,
    OP_SIN_MULX,
    OP_SIN_END,
    OP_AX,
    OP_AY,
    OP_PAX,
    OP_PAY,
    OP_VX_ADD,
    OP_VY_ADD,
    OP_VX_DAMP,
    OP_VY_DAMP,
    OP_M2A,
    OP_M2B,
    OP_CMP,
    OP_SQRT_STEP,
    OP_DIVX_MUL,
    OP_DIVX_INIT,
    OP_DIVX_END,
    OP_DIVY_INIT,
    OP_DIVY_END,
    OP_DIV_STEP,
    OP_PX_MUL,
    OP_PY_MUL,
    OP_AXX_H,
    OP_AXX_L,
    OP_AXX_S,
    OP_AYY_L,
    OP_AYY_S,
    OP_PX_UPD,
    OP_PY_UPD,
    OP_HD_UPD,
    OP_FINISH
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic clamp;
  } status_t;

  // program addresses where the sequencer branches
  localparam logic [5:0] PC_CMP       = 6'd32;
  localparam logic [5:0] PC_DIVX_INIT = 6'd34;
  localparam logic [5:0] PC_DIVY_INIT = 6'd36;
  localparam logic [5:0] PC_POS       = 6'd38;
  localparam logic [5:0] PC_LAST      = 6'd47;

  // one motion step; each op consumes the previous product and may start the next
  function automatic op_e prog(input logic [5:0] pc);
    op_e o;
    unique case (pc)
      6'd0, 6'd11: o = (pc == 6'd0) ? OP_CSIN_INIT : OP_SSIN_INIT;
      6'd1, 6'd12: o = OP_SIN_X2;
      6'd2, 6'd4, 6'd6, 6'd8, 6'd13, 6'd15, 6'd17, 6'd19: o = OP_SIN_SUB;
      6'd3, 6'd5, 6'd7, 6'd14, 6'd16, 6'd18: o = OP_SIN_MUL;
      6'd9, 6'd20: o = OP_SIN_MULX;
      6'd10, 6'd21: o = OP_SIN_END;
      6'd22: o = OP_AX;
      6'd23: o = OP_AY;
      6'd24: o = OP_PAX;
      6'd25: o = OP_PAY;
      6'd26: o = OP_VX_ADD;
      6'd27: o = OP_VY_ADD;
      6'd28: o = OP_VX_DAMP;
      6'd29: o = OP_VY_DAMP;
      6'd30: o = OP_M2A;
      6'd31: o = OP_M2B;
      6'd32: o = OP_CMP;
      6'd33: o = OP_DIVX_MUL;
      6'd34: o = OP_DIVX_INIT;
      6'd35: o = OP_DIVX_END;
      6'd36: o = OP_DIVY_INIT;
      6'd37: o = OP_DIVY_END;
      6'd38: o = OP_PX_MUL;
      6'd39: o = OP_PY_MUL;
      6'd40: o = OP_AXX_H;
      6'd41: o = OP_AXX_L;
      6'd42: o = OP_AXX_S;
      6'd43: o = OP_AYY_L;
      6'd44: o = OP_AYY_S;
      6'd45: o = OP_PX_UPD;
      6'd46: o = OP_PY_UPD;
      6'd47: o = OP_HD_UPD;
      default: o = OP_NOP;
    endcase
    return o;
  endfunction

  function automatic logic signed [32:0] sin_coef(input logic [1:0] idx);
    logic signed [32:0] c;
    unique case (idx)
      2'd0: c = SIN_C7;
      2'd1: c = SIN_C5;
      2'd2: c = SIN_C3;
      default: c = SIN_C1;
    endcase
    return c;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: src/dhms_ctrl.sv
module dhms_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dhms_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dhms_pkg::cmd_t      cmd_o,
  input  dhms_pkg::status_t   status_i
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RUN  = 5'b00010,
    S_SQRT = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e                      state_q, state_d;
  logic [5:0]                  pc_q, pc_d;
  logic [dhms_pkg::ITER_W-1:0] iter_q, iter_d;
  logic [dhms_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic                        out_valid_q, out_valid_d;
  logic [dhms_pkg::CNT_W-1:0]  step_lim;
  logic                        accept;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    if (32'(in_data_i.step_count) > 32'(dhms_pkg::MAX_FORECAST_STEPS)) begin
      step_lim = dhms_pkg::CNT_W'(dhms_pkg::MAX_FORECAST_STEPS);
    end else begin
      step_lim = dhms_pkg::CNT_W'(in_data_i.step_count);
    end
  end

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    iter_d      = iter_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o.op    = dhms_pkg::OP_NOP;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.op = dhms_pkg::OP_LOAD;
          pc_d     = '0;
          if (in_data_i.command == dhms_pkg::CMD_FORECAST) begin
            cnt_d   = step_lim;
            state_d = (step_lim == '0) ? S_DONE : S_RUN;
          end else begin
            cnt_d   = dhms_pkg::CNT_W'(1);
            state_d = S_RUN;
          end
        end
      end
      S_RUN: begin
        cmd_o.op = dhms_pkg::prog(pc_q);
        pc_d     = pc_q + 6'd1;
        iter_d   = '0;
        if (pc_q == dhms_pkg::PC_CMP) begin
          if (status_i.clamp) begin
            state_d = S_SQRT;
          end else begin
            pc_d = dhms_pkg::PC_POS;
          end
        end else if (pc_q == dhms_pkg::PC_DIVX_INIT || pc_q == dhms_pkg::PC_DIVY_INIT) begin
          state_d = S_DIV;
        end else if (pc_q == dhms_pkg::PC_LAST) begin
          if (cnt_q > dhms_pkg::CNT_W'(1)) begin
            cnt_d = cnt_q - dhms_pkg::CNT_W'(1);
            pc_d  = '0;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_SQRT, S_DIV: begin
        cmd_o.op = (state_q == S_SQRT) ? dhms_pkg::OP_SQRT_STEP : dhms_pkg::OP_DIV_STEP;
        iter_d   = iter_q + dhms_pkg::ITER_W'(1);
        if (iter_q == dhms_pkg::ITER_W'(dhms_pkg::ITER_STEPS - 1)) begin
          state_d = S_RUN;
        end
      end
      S_DONE: begin
        // result register must be free or drained this cycle
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.op    = dhms_pkg::OP_FINISH;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= '0;
      iter_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      iter_q      <= iter_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: src/dhms_datapath.sv
module dhms_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dhms_pkg::cmd_t      cmd_i,
  output dhms_pkg::status_t   status_o,
  input  dhms_pkg::in_word_t  in_data_i,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  output dhms_pkg::out_word_t out_data_o
);

  // configuration
  logic signed [31:0] start_x_q, start_y_q;
  logic [16:0]        damping_q;
  logic [30:0]        speed_limit_q;
  logic [19:0]        fstep_q;

  // stored body state
  logic signed [31:0] pos_x_q, pos_y_q, vel_x_q, vel_y_q;
  logic [31:0]        head_q;
  logic               started_q;

  // working copy and temporaries
  logic signed [31:0] bx_q, by_q, vx_q, vy_q;
  logic [31:0]        hd_q;
  logic signed [19:0] acc_q, turn_q;
  logic [19:0]        dt_q;
  logic               cmd_q;
  logic [30:0]        sx_q, x2_q;
  logic               sneg_q, swhich_q;
  logic signed [32:0] r_q;
  logic [1:0]         cidx_q;
  logic signed [31:0] cs_q, sn_q;
  logic signed [23:0] ax_q, ay_q;
  logic signed [47:0] pax_q, pay_q;
  logic [63:0]        m2_q, srem_q, root_q, bit_q;
  logic [31:0]        drem_q, dlo_q;
  logic signed [35:0] tvx_q, tvy_q;
  logic signed [53:0] qh_q;
  logic signed [38:0] ex_q, ey_q;
  logic signed [65:0] prod_q, prod_d;
  dhms_pkg::out_word_t out_q;

  logic signed [32:0] ma, mb;
  logic [31:0]        angle;
  logic [30:0]        xs;
  logic signed [32:0] sin_v;
  logic signed [31:0] sin_res;
  logic signed [32:0] mag_x, mag_y;
  logic [63:0]        s_try;
  logic               s_ge;
  logic [32:0]        d_try;
  logic               d_ge;
  logic [31:0]        d_sub;
  logic [31:0]        q_res;
  logic [71:0]        e_sum;
  logic signed [24:0] tr;
  dhms_pkg::op_e      op;

  assign op = cmd_i.op;
  assign out_data_o = out_q;
  assign status_o.clamp = m2_q > prod_q[63:0];

  always_comb begin
    angle = (op == dhms_pkg::OP_CSIN_INIT) ? hd_q + dhms_pkg::QUARTER : hd_q;
    xs    = angle[30] ? 31'(dhms_pkg::QUARTER) - {1'b0, angle[29:0]} : {1'b0, angle[29:0]};
    sin_v   = $signed(prod_q[62:30]);
    sin_res = sneg_q ? 32'(-sin_v) : 32'(sin_v);
    mag_x = vx_q[31] ? -33'(vx_q) : 33'(vx_q);
    mag_y = vy_q[31] ? -33'(vy_q) : 33'(vy_q);
    s_try = root_q + bit_q;
    s_ge  = srem_q >= s_try;
    d_try = {drem_q, dlo_q[31]};
    d_ge  = d_try >= root_q[32:0];
    d_sub = 32'(d_try - root_q[32:0]);
    // dlo_q holds the quotient; restore the sign of the component being rescaled
    q_res = ((op == dhms_pkg::OP_DIVX_END) ? vx_q[31] : vy_q[31]) ? -dlo_q : dlo_q;
    // (p >> 16) * dt * 2^16 + (p & 0xffff) * dt, then >> 33
    e_sum = 72'($signed({qh_q, 16'h0000})) + 72'(prod_q[36:0]);
    tr    = $signed(prod_q[40:16]);
  end

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (op)
      dhms_pkg::OP_CSIN_INIT, dhms_pkg::OP_SSIN_INIT: begin
        ma = {2'b00, xs};
        mb = {2'b00, xs};
      end
      dhms_pkg::OP_SIN_X2: begin
        ma = dhms_pkg::SIN_C9;
        mb = {2'b00, prod_q[60:30]};
      end
      dhms_pkg::OP_SIN_MUL: begin
        ma = r_q;
        mb = {2'b00, x2_q};
      end
      dhms_pkg::OP_SIN_MULX: begin
        ma = r_q;
        mb = {2'b00, sx_q};
      end
      dhms_pkg::OP_AX: begin
        ma = 33'(acc_q);
        mb = 33'(cs_q);
      end
      dhms_pkg::OP_AY: begin
        ma = 33'(acc_q);
        mb = 33'(sn_q);
      end
      dhms_pkg::OP_PAX: begin
        ma = 33'(ax_q);
        mb = {13'd0, dt_q};
      end
      dhms_pkg::OP_PAY: begin
        ma = 33'(ay_q);
        mb = {13'd0, dt_q};
      end
      dhms_pkg::OP_VY_ADD: begin
        ma = 33'(vx_q);
        mb = {16'd0, damping_q};
      end
      dhms_pkg::OP_VX_DAMP: begin
        ma = 33'(vy_q);
        mb = {16'd0, damping_q};
      end
      dhms_pkg::OP_VY_DAMP: begin
        ma = 33'(vx_q);
        mb = 33'(vx_q);
      end
      dhms_pkg::OP_M2A: begin
        ma = 33'(vy_q);
        mb = 33'(vy_q);
      end
      dhms_pkg::OP_M2B: begin
        ma = {2'b00, speed_limit_q};
        mb = {2'b00, speed_limit_q};
      end
      dhms_pkg::OP_DIVX_MUL: begin
        ma = mag_x;
        mb = {2'b00, speed_limit_q};
      end
      dhms_pkg::OP_DIVX_END: begin
        ma = mag_y;
        mb = {2'b00, speed_limit_q};
      end
      dhms_pkg::OP_PX_MUL: begin
        ma = 33'(vx_q);
        mb = {13'd0, dt_q};
      end
      dhms_pkg::OP_PY_MUL: begin
        ma = 33'(vy_q);
        mb = {13'd0, dt_q};
      end
      dhms_pkg::OP_AXX_H: begin
        ma = 33'($signed(pax_q[47:16]));
        mb = {13'd0, dt_q};
      end
      dhms_pkg::OP_AXX_L: begin
        ma = {17'd0, pax_q[15:0]};
        mb = {13'd0, dt_q};
      end
      dhms_pkg::OP_AXX_S: begin
        ma = 33'($signed(pay_q[47:16]));
        mb = {13'd0, dt_q};
      end
      dhms_pkg::OP_AYY_L: begin
        ma = {17'd0, pay_q[15:0]};
        mb = {13'd0, dt_q};
      end
      dhms_pkg::OP_PX_UPD: begin
        ma = 33'(turn_q);
        mb = {13'd0, dt_q};
      end
      dhms_pkg::OP_PY_UPD: begin
        ma = 33'(tr);
        mb = dhms_pkg::INV_TWO_PI;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod_d = ma * mb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q     <= '0;
      start_y_q     <= '0;
      damping_q     <= dhms_pkg::DAMPING_RST;
      speed_limit_q <= dhms_pkg::SPEED_LIMIT_RST;
      fstep_q       <= dhms_pkg::FSTEP_RST;
      pos_x_q       <= '0;
      pos_y_q       <= '0;
      vel_x_q       <= '0;
      vel_y_q       <= '0;
      head_q        <= '0;
      started_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          dhms_pkg::CFG_START_X:       start_x_q     <= $signed(cfg_data_i);
          dhms_pkg::CFG_START_Y:       start_y_q     <= $signed(cfg_data_i);
          dhms_pkg::CFG_DAMPING:       damping_q     <= cfg_data_i[16:0];
          dhms_pkg::CFG_SPEED_LIMIT:   speed_limit_q <= cfg_data_i[30:0];
          dhms_pkg::CFG_FORECAST_STEP: fstep_q       <= cfg_data_i[19:0];
          default: ;
        endcase
      end
      if (op == dhms_pkg::OP_FINISH && cmd_q == dhms_pkg::CMD_ADVANCE) begin
        pos_x_q   <= bx_q;
        pos_y_q   <= by_q;
        vel_x_q   <= vx_q;
        vel_y_q   <= vy_q;
        head_q    <= hd_q;
        started_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    unique case (op)
      dhms_pkg::OP_LOAD: begin
        bx_q   <= started_q ? pos_x_q : start_x_q;
        by_q   <= started_q ? pos_y_q : start_y_q;
        vx_q   <= vel_x_q;
        vy_q   <= vel_y_q;
        hd_q   <= head_q;
        acc_q  <= in_data_i.accel;
        turn_q <= in_data_i.turn_rate;
        cmd_q  <= in_data_i.command;
        // first advance runs with zero time
        if (in_data_i.command == dhms_pkg::CMD_FORECAST) begin
          dt_q <= fstep_q;
        end else begin
          dt_q <= started_q ? in_data_i.delta_time : '0;
        end
      end
      dhms_pkg::OP_CSIN_INIT, dhms_pkg::OP_SSIN_INIT: begin
        sx_q     <= xs;
        sneg_q   <= angle[31];
        swhich_q <= (op == dhms_pkg::OP_SSIN_INIT);
      end
      dhms_pkg::OP_SIN_X2: begin
        x2_q   <= prod_q[60:30];
        r_q    <= dhms_pkg::SIN_C9;
        cidx_q <= '0;
      end
      dhms_pkg::OP_SIN_SUB: begin
        r_q    <= dhms_pkg::sin_coef(cidx_q) - $signed(prod_q[62:30]);
        cidx_q <= cidx_q + 2'd1;
      end
      dhms_pkg::OP_SIN_END: begin
        if (swhich_q) begin
          sn_q <= sin_res;
        end else begin
          cs_q <= sin_res;
        end
      end
      dhms_pkg::OP_AY:     ax_q  <= $signed(prod_q[53:30]);
      dhms_pkg::OP_PAX:    ay_q  <= $signed(prod_q[53:30]);
      dhms_pkg::OP_PAY:    pax_q <= $signed(prod_q[47:0]);
      dhms_pkg::OP_VX_ADD: begin
        pay_q <= $signed(prod_q[47:0]);
        vx_q  <= dhms_pkg::sat32(40'(vx_q) + 40'($signed(pax_q[47:16])));
      end
      dhms_pkg::OP_VY_ADD:  vy_q <= dhms_pkg::sat32(40'(vy_q) + 40'($signed(pay_q[47:16])));
      dhms_pkg::OP_VX_DAMP: vx_q <= dhms_pkg::sat32($signed(prod_q[55:16]));
      dhms_pkg::OP_VY_DAMP: vy_q <= dhms_pkg::sat32($signed(prod_q[55:16]));
      dhms_pkg::OP_M2A:     m2_q <= prod_q[63:0];
      dhms_pkg::OP_M2B:     m2_q <= m2_q + prod_q[63:0];
      dhms_pkg::OP_CMP: begin
        srem_q <= m2_q;
        root_q <= '0;
        bit_q  <= 64'h4000_0000_0000_0000;
      end
      dhms_pkg::OP_SQRT_STEP: begin
        if (s_ge) begin
          srem_q <= srem_q - s_try;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      dhms_pkg::OP_DIVX_INIT, dhms_pkg::OP_DIVY_INIT: begin
        drem_q <= {2'b00, prod_q[61:32]};
        dlo_q  <= prod_q[31:0];
      end
      dhms_pkg::OP_DIV_STEP: begin
        drem_q <= d_ge ? d_sub : d_try[31:0];
        dlo_q  <= {dlo_q[30:0], d_ge};
      end
      dhms_pkg::OP_DIVX_END: vx_q <= $signed(q_res);
      dhms_pkg::OP_DIVY_END: vy_q <= $signed(q_res);
      dhms_pkg::OP_PY_MUL:   tvx_q <= $signed(prod_q[51:16]);
      dhms_pkg::OP_AXX_H:    tvy_q <= $signed(prod_q[51:16]);
      dhms_pkg::OP_AXX_L, dhms_pkg::OP_AYY_L: qh_q <= $signed(prod_q[53:0]);
      dhms_pkg::OP_AXX_S:    ex_q <= $signed(e_sum[71:33]);
      dhms_pkg::OP_AYY_S:    ey_q <= $signed(e_sum[71:33]);
      dhms_pkg::OP_PX_UPD:   bx_q <= dhms_pkg::sat32(40'(bx_q) + 40'(tvx_q) + 40'(ex_q));
      dhms_pkg::OP_PY_UPD:   by_q <= dhms_pkg::sat32(40'(by_q) + 40'(tvy_q) + 40'(ey_q));
      dhms_pkg::OP_HD_UPD:   hd_q <= hd_q + prod_q[47:16];
      dhms_pkg::OP_FINISH: begin
        out_q.pos_x   <= bx_q;
        out_q.pos_y   <= by_q;
        out_q.vel_x   <= vx_q;
        out_q.vel_y   <= vy_q;
        out_q.heading <= hd_q;
      end
      default: ;
    endcase
  end

endmodule

// File: src/damped_heading_motion_step_unit.sv
// One motion step runs the op program; when the speed clamp fires it adds a square root
// and two restoring divides. All products come from one shared 33x33 multiplier path.
// Advance runs one step from accept to result; a forecast of N steps runs N of them.
// One word in flight; the next is taken once the result is in the output register.
// Reset clears state, config defaults and all handshakes.
module damped_heading_motion_step_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dhms_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dhms_pkg::out_word_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);

  dhms_pkg::cmd_t    cmd;
  dhms_pkg::status_t status;

  dhms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  dhms_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_data_o  (out_data_o)
  );

endmodule
